// ===== design/vbe_sds_pkg.sv =====
package vbe_sds_pkg;

  // request codes
  localparam logic [2:0] OP_SET_PIXELS = 3'd0;
  localparam logic [2:0] OP_GET_LENGTHS = 3'd1;
  localparam logic [2:0] OP_SET_BYTES = 3'd2;
  localparam logic [2:0] OP_GET_MAX = 3'd3;
  localparam logic [2:0] OP_SET_START = 3'd4;
  localparam logic [2:0] OP_GET_START = 3'd5;
  localparam logic [2:0] OP_RAW_START = 3'd6;
  localparam logic [2:0] OP_ILLEGAL = 3'd7;

  // mode types
  localparam logic [2:0] MODE_PLANAR4 = 3'd0;
  localparam logic [2:0] MODE_PACKED8 = 3'd1;
  localparam logic [2:0] MODE_RGB15 = 3'd2;
  localparam logic [2:0] MODE_RGB16 = 3'd3;
  localparam logic [2:0] MODE_RGB32 = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VMEM_SIZE = 1'd1;

  localparam logic [2:0] MODE_RESET = MODE_PACKED8;
  localparam logic [24:0] VMEM_RESET = 25'd2097152;
  localparam logic [15:0] MAX_LINE_BYTES = 16'd4096;

  // divider geometry
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 19;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef struct packed {
    logic [2:0] op;
    logic [15:0] value_x;
    logic [15:0] coord_y;
    logic [31:0] raw_start;
  } in_word_t;

  typedef struct packed {
    logic status;
    logic [15:0] line_bytes;
    logic [15:0] line_pixels;
    logic [15:0] line_count;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } out_word_t;

  // microcode fields
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_STORE_LEN,
    ACT_LEN_RPT,
    ACT_CNT_WB,
    ACT_MAX_RPT,
    ACT_MUL,
    ACT_SET_START,
    ACT_START_DIV,
    ACT_GS_WB,
    ACT_FAIL,
    ACT_RAW
  } act_t;

  typedef enum logic [2:0] {
    SEQ_DISPATCH,
    SEQ_NEXT,
    SEQ_BRANCH,
    SEQ_GOTO,
    SEQ_WAIT,
    SEQ_FINISH
  } seq_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_UNSUP,
    COND_LENZ,
    COND_GSBAD
  } cond_t;

  localparam int PC_W = 5;

  typedef struct packed {
    act_t act;
    seq_t seq;
    cond_t cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic unsup;
    logic lenz;
    logic gsbad;
  } cond_flags_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
  localparam logic [PC_W-1:0] PC_SETLEN = 5'd1;
  localparam logic [PC_W-1:0] PC_STORE = 5'd2;
  localparam logic [PC_W-1:0] PC_GETLEN = 5'd3;
  localparam logic [PC_W-1:0] PC_LENRPT = 5'd4;
  localparam logic [PC_W-1:0] PC_LENWAIT = 5'd5;
  localparam logic [PC_W-1:0] PC_CNTWB = 5'd6;
  localparam logic [PC_W-1:0] PC_FINISH = 5'd7;
  localparam logic [PC_W-1:0] PC_GETMAX = 5'd8;
  localparam logic [PC_W-1:0] PC_MAXRPT = 5'd9;
  localparam logic [PC_W-1:0] PC_SETSTART = 5'd10;
  localparam logic [PC_W-1:0] PC_STARTWB = 5'd11;
  localparam logic [PC_W-1:0] PC_GETSTART = 5'd12;
  localparam logic [PC_W-1:0] PC_GSWAIT = 5'd13;
  localparam logic [PC_W-1:0] PC_GSWB = 5'd14;
  localparam logic [PC_W-1:0] PC_FAIL = 5'd15;
  localparam logic [PC_W-1:0] PC_RAW = 5'd16;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: ACT_NONE, seq: SEQ_GOTO, cond: COND_NONE, target: PC_IDLE};
    case (pc)
      PC_IDLE: w = '{ACT_NONE, SEQ_DISPATCH, COND_NONE, PC_IDLE};
      PC_SETLEN: w = '{ACT_NONE, SEQ_BRANCH, COND_UNSUP, PC_FAIL};
      PC_STORE: w = '{ACT_STORE_LEN, SEQ_NEXT, COND_NONE, PC_IDLE};
      PC_GETLEN: w = '{ACT_NONE, SEQ_BRANCH, COND_UNSUP, PC_FAIL};
      PC_LENRPT: w = '{ACT_LEN_RPT, SEQ_BRANCH, COND_LENZ, PC_FAIL};
      PC_LENWAIT: w = '{ACT_NONE, SEQ_WAIT, COND_NONE, PC_IDLE};
      PC_CNTWB: w = '{ACT_CNT_WB, SEQ_NEXT, COND_NONE, PC_IDLE};
      PC_FINISH: w = '{ACT_NONE, SEQ_FINISH, COND_NONE, PC_IDLE};
      PC_GETMAX: w = '{ACT_NONE, SEQ_BRANCH, COND_UNSUP, PC_FAIL};
      PC_MAXRPT: w = '{ACT_MAX_RPT, SEQ_GOTO, COND_NONE, PC_FINISH};
      PC_SETSTART: w = '{ACT_MUL, SEQ_BRANCH, COND_UNSUP, PC_FAIL};
      PC_STARTWB: w = '{ACT_SET_START, SEQ_GOTO, COND_NONE, PC_FINISH};
      PC_GETSTART: w = '{ACT_START_DIV, SEQ_BRANCH, COND_GSBAD, PC_FAIL};
      PC_GSWAIT: w = '{ACT_NONE, SEQ_WAIT, COND_NONE, PC_IDLE};
      PC_GSWB: w = '{ACT_GS_WB, SEQ_GOTO, COND_NONE, PC_FINISH};
      PC_FAIL: w = '{ACT_FAIL, SEQ_GOTO, COND_NONE, PC_FINISH};
      PC_RAW: w = '{ACT_RAW, SEQ_GOTO, COND_NONE, PC_FINISH};
      default: w = '{ACT_NONE, SEQ_GOTO, COND_NONE, PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] op_entry(input logic [2:0] op);
    logic [PC_W-1:0] a;
    a = PC_FAIL;
    case (op)
      OP_SET_PIXELS: a = PC_SETLEN;
      OP_SET_BYTES: a = PC_SETLEN;
      OP_GET_LENGTHS: a = PC_GETLEN;
      OP_GET_MAX: a = PC_GETMAX;
      OP_SET_START: a = PC_SETSTART;
      OP_GET_START: a = PC_GETSTART;
      OP_RAW_START: a = PC_RAW;
      OP_ILLEGAL: a = PC_FAIL;
      default: a = PC_FAIL;
    endcase
    return a;
  endfunction

  // log2 of bytes per pixel; planar 4bpp also gives 0
  function automatic logic [1:0] bpp_shift(input logic [2:0] mode);
    logic [1:0] s;
    s = 2'd0;
    case (mode)
      MODE_RGB15: s = 2'd1;
      MODE_RGB16: s = 2'd1;
      MODE_RGB32: s = 2'd2;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/vbe_sds_div.sv =====
module vbe_sds_div import vbe_sds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_NUM_W-1:0] quot,
  output logic [DIV_DEN_W-1:0] rem
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0] shifted;
  logic take;

  // restoring, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r[DIV_DEN_W-1:0], quo_r[DIV_NUM_W-1]};
    take = shifted >= {1'b0, den_r};
    rem_nxt = take ? shifted - {1'b0, den_r} : shifted;
    quo_nxt = {quo_r[DIV_NUM_W-2:0], take};
    cnt_nxt = cnt_r - DIV_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = cnt_r != '0;
  assign quot = quo_r;
  assign rem = rem_r[DIV_DEN_W-1:0];

endmodule

// ===== design/vbe_sds_seq.sv =====
module vbe_sds_seq import vbe_sds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [2:0]  in_op,
  input  cond_flags_t flags,
  input  logic        div_busy,
  input  logic        out_free,
  output uword_t      uw,
  output logic        idle
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic cond_hit;

  assign uw = ucode_rom(pc_r);
  assign idle = uw.seq == SEQ_DISPATCH;

  always_comb begin
    cond_hit = 1'b0;
    case (uw.cond)
      COND_UNSUP: cond_hit = flags.unsup;
      COND_LENZ: cond_hit = flags.lenz;
      COND_GSBAD: cond_hit = flags.gsbad;
      default: cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    case (uw.seq)
      SEQ_DISPATCH: pc_nxt = in_fire ? op_entry(in_op) : pc_r;
      SEQ_NEXT: pc_nxt = pc_r + PC_W'(1);
      SEQ_BRANCH: pc_nxt = cond_hit ? uw.target : pc_r + PC_W'(1);
      SEQ_GOTO: pc_nxt = uw.target;
      SEQ_WAIT: pc_nxt = div_busy ? pc_r : pc_r + PC_W'(1);
      SEQ_FINISH: pc_nxt = out_free ? PC_IDLE : pc_r;
      default: pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== design/vbe_scanline_display_start.sv =====
// VBE scan-line length and display-start service block.
// Input channel in_valid/in_ready/in_word carries one request word (op,
// value_x, coord_y, raw_start); out_valid/out_ready/out_word returns one
// result word per request. cfg_valid/cfg_ready/cfg_index/cfg_data writes
// mode_type (index 0) or vmem_size (index 1); cfg_ready is always high.
// A microcoded sequencer runs one request at a time. Get max, set start,
// raw start, illegal op and early failures skip the divider; get lengths,
// set lengths and get start run the shared bit-serial divider. No new
// request is accepted until the current one leaves its final step. The
// result sits in an output register, so the next request is accepted while
// a result waits; a stalled receiver holds the sequencer only at its final
// step. Reset (rst_n low, synchronous) clears line length, display start
// and panning, sets mode_type to packed 8bpp and vmem_size to 2 MiB.
module vbe_scanline_display_start import vbe_sds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0] mode_r;
  logic [24:0] vmem_r;
  in_word_t word_r;
  logic [15:0] lu_r;
  logic [31:0] start_r;
  logic [3:0] pan_r;
  logic [31:0] prod_r;
  out_word_t res_r;
  logic out_valid_r;
  out_word_t out_word_r;

  uword_t uw;
  cond_flags_t flags;
  logic idle, in_fire, out_free;

  logic div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den, div_rem;

  logic planar;
  logic [1:0] sh;
  logic [18:0] len_raw, len_up, lu8, lu8_sh, gs_x;
  logic [15:0] rpt_bytes, rpt_pixels;
  logic [17:0] rpt_div;
  logic [19:0] mul_factor;
  logic [35:0] mul_full;
  logic [31:0] add_term, s_sum;

  assign cfg_ready = 1'b1;
  assign in_ready = idle;
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  always_comb begin
    planar = mode_r == MODE_PLANAR4;
    sh = bpp_shift(mode_r);

    if (word_r.op == OP_SET_PIXELS) begin
      len_raw = planar ? {4'b0, word_r.value_x[15:1]} : ({3'b0, word_r.value_x} << sh);
    end else begin
      len_raw = planar ? {1'b0, word_r.value_x, 2'b0} : {3'b0, word_r.value_x};
    end
    len_up = (len_raw[2:0] != 3'd0) ? len_raw + 19'd8 : len_raw;

    lu8 = {lu_r, 3'b0};
    lu8_sh = lu8 >> sh;
    rpt_bytes = planar ? {lu_r[14:0], 1'b0} : lu8[15:0];
    rpt_pixels = planar ? {lu_r[11:0], 4'b0} : lu8_sh[15:0];
    rpt_div = planar ? {rpt_bytes, 2'b0} : {2'b0, rpt_bytes};

    mul_factor = planar ? {lu_r, 4'b0} : {1'b0, lu8};
    mul_full = mul_factor * word_r.coord_y;
    add_term = (mode_r == MODE_PLANAR4 || mode_r == MODE_PACKED8) ?
               {16'b0, word_r.value_x} : ({16'b0, word_r.value_x} << sh);
    s_sum = prod_r + add_term;

    gs_x = div_rem + {15'b0, pan_r};

    flags.unsup = mode_r > MODE_RGB32;
    flags.lenz = rpt_div == 18'd0;
    flags.gsbad = (lu_r == 16'd0) || (mode_r != MODE_PACKED8);
  end

  always_comb begin
    div_start = 1'b0;
    div_num = {7'b0, vmem_r};
    div_den = {1'b0, rpt_div};
    case (uw.act)
      ACT_LEN_RPT: div_start = !flags.lenz;
      ACT_START_DIV: begin
        div_start = !flags.gsbad;
        div_num = {start_r[29:0], 2'b0};
        div_den = lu8;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      vmem_r <= VMEM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE_TYPE: mode_r <= cfg_data[2:0];
        CFG_VMEM_SIZE: vmem_r <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lu_r <= '0;
      start_r <= '0;
      pan_r <= '0;
    end else begin
      case (uw.act)
        ACT_STORE_LEN: lu_r <= len_up[18:3];
        ACT_SET_START: begin
          if (planar) begin
            start_r <= {3'b0, s_sum[31:3]};
            pan_r <= {1'b0, s_sum[2:0]};
          end else if (mode_r == MODE_PACKED8) begin
            start_r <= {2'b0, s_sum[31:2]};
            pan_r <= {1'b0, s_sum[1:0], 1'b0};
          end else begin
            start_r <= {2'b0, s_sum[31:2]};
          end
        end
        ACT_RAW: start_r <= word_r.raw_start;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uw.act)
      ACT_MUL: prod_r <= mul_full[31:0];
      ACT_LEN_RPT: begin
        res_r <= '{status: 1'b0, line_bytes: rpt_bytes, line_pixels: rpt_pixels,
                   line_count: 16'd0, start_x: 16'd0, start_y: 16'd0};
      end
      ACT_CNT_WB: res_r.line_count <= div_quot[15:0];
      ACT_MAX_RPT: begin
        res_r <= '{status: 1'b0, line_bytes: MAX_LINE_BYTES,
                   line_pixels: MAX_LINE_BYTES >> sh,
                   line_count: {3'b0, vmem_r[24:12]},
                   start_x: 16'd0, start_y: 16'd0};
      end
      ACT_SET_START: res_r <= '0;
      ACT_GS_WB: begin
        res_r <= '{status: 1'b0, line_bytes: 16'd0, line_pixels: 16'd0,
                   line_count: 16'd0, start_x: gs_x[15:0],
                   start_y: div_quot[15:0]};
      end
      ACT_RAW: res_r <= '0;
      ACT_FAIL: begin
        res_r <= '{status: 1'b1, line_bytes: 16'd0, line_pixels: 16'd0,
                   line_count: 16'd0, start_x: 16'd0, start_y: 16'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.seq == SEQ_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.seq == SEQ_FINISH && out_free) begin
      out_word_r <= res_r;
    end
  end

  vbe_sds_seq u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .in_fire(in_fire),
    .in_op(in_word.op),
    .flags(flags),
    .div_busy(div_busy),
    .out_free(out_free),
    .uw(uw),
    .idle(idle)
  );

  vbe_sds_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .dividend(div_num),
    .divisor(div_den),
    .busy(div_busy),
    .quot(div_quot),
    .rem(div_rem)
  );

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer stayed at dispatch after accept");

  a_div_idle_at_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> !in_ready)
    else $error("divider running while sequencer dispatches");

  a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status |->
      out_word.line_bytes == 16'd0 && out_word.line_pixels == 16'd0 &&
      out_word.line_count == 16'd0 && out_word.start_x == 16'd0 &&
      out_word.start_y == 16'd0)
    else $error("failed result carries nonzero fields");

endmodule
